@@ rtl/ogq_pkg.sv @@
// shared types and codes for the occupancy grid query engine
// no dependencies; used by ogq_ctrl, ogq_dp and the top level
package ogq_pkg;

   // request kinds carried on req_tuser
   localparam logic [2:0] OP_LOAD    = 3'd0;
   localparam logic [2:0] OP_CHECK   = 3'd1;
   localparam logic [2:0] OP_POINT   = 3'd2;
   localparam logic [2:0] OP_ZONE    = 3'd3;
   localparam logic [2:0] OP_NEAREST = 3'd4;

   // check byte outcome
   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_MISMATCH = 2'd1;
   localparam logic [1:0] ST_SHORT    = 2'd2;

   localparam logic [12:0] DIST_MAX  = 13'd8191;
   localparam logic [7:0]  BIT_MASK  = 8'h01;

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic load_op;
      logic check_op;
      logic div_step;
      logic point_rd;
      logic scan_rd;
      logic scan_acc;
      logic sqrt_init;
      logic sqrt_step;
      logic out_load;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [2:0] op;
      logic       div_done;
      logic       scan_last;
      logic       scan_hit;
      logic       sqrt_done;
   } sts_type;

endpackage

@@ rtl/ogq_ram.sv @@
// generic single write port ram with registered read
// no dependencies
module ogq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/ogq_ctrl.sv @@
// sequencer for the occupancy grid query engine
// depends on ogq_pkg for the command and status structs
module ogq_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   input  ogq_pkg::sts_type sts,
   output ogq_pkg::cmd_type cmd
);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_DEC  = 4'd1;
   localparam logic [3:0] S_DIV  = 4'd2;
   localparam logic [3:0] S_PRD  = 4'd3;
   localparam logic [3:0] S_PBIT = 4'd4;
   localparam logic [3:0] S_SCA  = 4'd5;
   localparam logic [3:0] S_SCB  = 4'd6;
   localparam logic [3:0] S_SQI  = 4'd7;
   localparam logic [3:0] S_SQR  = 4'd8;
   localparam logic [3:0] S_FIN  = 4'd9;

   logic [3:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = S_DEC;
            end
         end
         S_DEC: begin
            unique case (sts.op) inside
               ogq_pkg::OP_LOAD: begin
                  cmd.load_op = 1'b1;
                  state_in    = S_FIN;
               end
               ogq_pkg::OP_CHECK: begin
                  cmd.check_op = 1'b1;
                  state_in     = S_FIN;
               end
               ogq_pkg::OP_POINT: state_in = S_DIV;
               ogq_pkg::OP_ZONE, ogq_pkg::OP_NEAREST: state_in = S_SCA;
               default: state_in = S_FIN;
            endcase
         end
         S_DIV: begin
            if (sts.div_done) begin
               cmd.point_rd = 1'b1;
               state_in     = S_PRD;
            end else begin
               cmd.div_step = 1'b1;
            end
         end
         S_PRD:  state_in = S_PBIT;
         S_PBIT: state_in = S_FIN;
         S_SCA: begin
            cmd.scan_rd = 1'b1;
            state_in    = S_SCB;
         end
         S_SCB: begin
            cmd.scan_acc = 1'b1;
            if ((sts.op == ogq_pkg::OP_ZONE && sts.scan_hit) || sts.scan_last) begin
               state_in = (sts.op == ogq_pkg::OP_NEAREST) ? S_SQI : S_FIN;
            end else begin
               state_in = S_SCA;
            end
         end
         S_SQI: begin
            cmd.sqrt_init = 1'b1;
            state_in      = S_SQR;
         end
         S_SQR: begin
            if (sts.sqrt_done) begin
               state_in = S_FIN;
            end else begin
               cmd.sqrt_step = 1'b1;
            end
         end
         S_FIN: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

`ifndef SYNTHESIS
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid_ff || rsp_tready))
      else $error("result overwritten before transfer");
   a_capture_decodes: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |=> state_ff == S_DEC)
      else $error("captured request not decoded");
   a_div_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV && !sts.div_done) |=> state_ff == S_DIV)
      else $error("division left early");
   a_sqrt_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SQR && sts.sqrt_done) |=> state_ff == S_FIN)
      else $error("square root did not finish");
`endif

endmodule

@@ rtl/ogq_dp.sv @@
// datapath: map banks, load and check, point divider, cell scan, square root
// depends on ogq_pkg and ogq_ram
module ogq_dp #(
   parameter int GRID_COLS = 32,
   parameter int GRID_ROWS = 16,
   parameter int CELL_MM   = 150
) (
   input  logic             clock,
   input  logic             reset,
   input  ogq_pkg::cmd_type cmd,
   output ogq_pkg::sts_type sts,
   input  logic [2:0]       req_tuser,
   input  logic [47:0]      req_tdata,
   output logic [23:0]      rsp_tdata
);

   localparam int CELL_COUNT = GRID_COLS * GRID_ROWS;
   localparam int MAP_BYTES  = (CELL_COUNT + 7) / 8;
   localparam int AW   = $clog2(MAP_BYTES);
   localparam int CW   = $clog2(CELL_COUNT);
   localparam int BCW  = $clog2(MAP_BYTES + 1);
   localparam int GXW  = $clog2(GRID_COLS);
   localparam int GYW  = $clog2(GRID_ROWS);
   localparam int MAXD = (GRID_COLS > GRID_ROWS) ? GRID_COLS : GRID_ROWS;
   localparam int DXW  = $clog2(2 * MAXD * CELL_MM + 16384) + 1;
   localparam int SQW  = 2 * DXW;
   localparam int SUMW = SQW + 1;
   localparam int RTW  = SUMW + (SUMW % 2);
   localparam int RH   = RTW / 2;
   localparam int RCW  = $clog2(RH + 1);
   // point cell: divide by the cell size with a reciprocal multiply
   localparam int SH    = 13 + $clog2(CELL_MM);
   localparam int RECIP = ((1 << SH) + CELL_MM - 1) / CELL_MM;
   localparam int RCPW  = $clog2(RECIP + 1);
   localparam int PW    = 13 + RCPW;

   // captured request
   logic [2:0]  op_ff;
   logic [7:0]  db_ff;

   // map bookkeeping
   logic [BCW-1:0] count_ff;
   logic [7:0]     xor_ff;
   logic           active_ff, loaded_ff;

   // divider
   logic [12:0]     xs_ff, ys_ff, xq_ff, yq_ff;
   logic            div_done_ff;
   logic [PW-1:0]   xprod, yprod;
   logic [GXW-1:0]  gxq;
   logic [GYW-1:0]  gyq;
   logic [CW-1:0]   pcell, pcell_ff;

   // scan
   logic [CW-1:0]          cell_ff;
   logic [GXW-1:0]         gx_ff;
   logic signed [DXW-1:0]  dx_ff, dy_ff, dx0_ff;
   logic [SQW-1:0]         sqx_ff, sqy_ff;
   logic [SUMW-1:0]        best_ff, sum;
   logic [27:0]            lim_ff;
   logic                   found_ff, occ_ff, cell_bit, hit;
   logic [2:0]             bit_idx;

   // square root
   logic [RTW-1:0]  rad_ff;
   logic [RH-1:0]   root_ff;
   logic [RH+1:0]   rem_ff, r2, trial;
   logic [RCW-1:0]  sq_cnt_ff;
   logic [RH-2:0]   root_half;
   logic [12:0]     dist_sat;

   // results
   logic [1:0]  status_ff;
   logic [1:0]  out_status_ff;
   logic        out_occ_ff, out_found_ff;
   logic [12:0] out_dist_ff;

   // ram
   logic          wr_en, wr_en0, wr_en1;
   logic [AW-1:0] rd_addr;
   logic [7:0]    rd0, rd1, rd_byte;

   assign wr_en  = cmd.load_op && (count_ff < BCW'(MAP_BYTES));
   assign wr_en0 = wr_en && active_ff;
   assign wr_en1 = wr_en && !active_ff;
   // a point query keeps its byte address on the ram until the next request
   assign rd_addr = cmd.point_rd ? AW'(pcell >> 3) :
                    (op_ff == ogq_pkg::OP_POINT) ? AW'(pcell_ff >> 3) : AW'(cell_ff >> 3);

   ogq_ram #(.WIDTH(8), .DEPTH(MAP_BYTES)) u_bank0 (
      .clock   (clock),
      .wr_en   (wr_en0),
      .wr_addr (AW'(count_ff)),
      .wr_data (db_ff),
      .rd_addr (rd_addr),
      .rd_data (rd0)
   );

   ogq_ram #(.WIDTH(8), .DEPTH(MAP_BYTES)) u_bank1 (
      .clock   (clock),
      .wr_en   (wr_en1),
      .wr_addr (AW'(count_ff)),
      .wr_data (db_ff),
      .rd_addr (rd_addr),
      .rd_data (rd1)
   );

   assign rd_byte  = active_ff ? rd1 : rd0;
   assign bit_idx  = (op_ff == ogq_pkg::OP_POINT) ? pcell_ff[2:0] : cell_ff[2:0];
   assign cell_bit = loaded_ff && (((rd_byte >> bit_idx) & ogq_pkg::BIT_MASK) != 8'd0);

   // divider and clamp
   assign xprod = PW'(xs_ff) * PW'(RECIP);
   assign yprod = PW'(ys_ff) * PW'(RECIP);
   assign gxq = (xq_ff >= 13'(GRID_COLS)) ? GXW'(GRID_COLS - 1) : xq_ff[GXW-1:0];
   assign gyq = (yq_ff >= 13'(GRID_ROWS)) ? GYW'(GRID_ROWS - 1) : yq_ff[GYW-1:0];
   assign pcell = CW'(gyq * GRID_COLS) + CW'(gxq);

   assign sum = SUMW'(sqx_ff) + SUMW'(sqy_ff);
   assign hit = cell_bit && (sum <= SUMW'(lim_ff));

   assign r2        = {rem_ff[RH-1:0], rad_ff[RTW-1 -: 2]};
   assign trial     = {root_ff, 2'b01};
   assign root_half = root_ff[RH-1:1];
   assign dist_sat = (root_half > (RH-1)'(ogq_pkg::DIST_MAX)) ? ogq_pkg::DIST_MAX
                                                               : root_half[12:0];

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff       <= req_tuser;
         db_ff       <= req_tdata[7:0];
         xs_ff       <= req_tdata[20:8];
         ys_ff       <= req_tdata[33:21];
         xq_ff       <= '0;
         yq_ff       <= '0;
         div_done_ff <= 1'b0;
         dx_ff       <= DXW'(CELL_MM) - DXW'({req_tdata[20:8], 1'b0});
         dx0_ff      <= DXW'(CELL_MM) - DXW'({req_tdata[20:8], 1'b0});
         dy_ff       <= DXW'(CELL_MM) - DXW'({req_tdata[33:21], 1'b0});
         lim_ff      <= 28'({req_tdata[46:34], 1'b0} * {req_tdata[46:34], 1'b0});
         cell_ff     <= '0;
         gx_ff       <= '0;
         best_ff     <= '0;
         found_ff    <= 1'b0;
         occ_ff      <= 1'b0;
         status_ff   <= ogq_pkg::ST_OK;
         root_ff     <= '0;
      end
      if (cmd.check_op) begin
         if (count_ff != BCW'(MAP_BYTES)) begin
            status_ff <= ogq_pkg::ST_SHORT;
         end else if (xor_ff != db_ff) begin
            status_ff <= ogq_pkg::ST_MISMATCH;
         end
      end
      if (cmd.div_step) begin
         xq_ff       <= 13'(xprod >> SH);
         yq_ff       <= 13'(yprod >> SH);
         div_done_ff <= 1'b1;
      end
      if (cmd.point_rd) begin
         pcell_ff <= pcell;
      end
      if (op_ff == ogq_pkg::OP_POINT && !cmd.capture) begin
         // point byte stays on the ram output from the cycle after the read
         occ_ff <= cell_bit;
      end
      if (cmd.scan_rd) begin
         sqx_ff <= $unsigned(SQW'(dx_ff * dx_ff));
         sqy_ff <= $unsigned(SQW'(dy_ff * dy_ff));
      end
      if (cmd.scan_acc) begin
         if (op_ff == ogq_pkg::OP_NEAREST && cell_bit) begin
            if (!found_ff || sum < best_ff) begin
               best_ff <= sum;
            end
            found_ff <= 1'b1;
         end
         if (op_ff == ogq_pkg::OP_ZONE && hit) begin
            occ_ff <= 1'b1;
         end
         cell_ff <= cell_ff + CW'(1);
         if (gx_ff == GXW'(GRID_COLS - 1)) begin
            gx_ff <= '0;
            dx_ff <= dx0_ff;
            dy_ff <= dy_ff + DXW'(2 * CELL_MM);
         end else begin
            gx_ff <= gx_ff + GXW'(1);
            dx_ff <= dx_ff + DXW'(2 * CELL_MM);
         end
      end
      if (cmd.sqrt_init) begin
         rad_ff    <= RTW'(best_ff);
         root_ff   <= '0;
         rem_ff    <= '0;
         sq_cnt_ff <= '0;
      end
      if (cmd.sqrt_step) begin
         rad_ff    <= {rad_ff[RTW-3:0], 2'b00};
         rem_ff    <= (r2 >= trial) ? r2 - trial : r2;
         root_ff   <= {root_ff[RH-2:0], r2 >= trial};
         sq_cnt_ff <= sq_cnt_ff + RCW'(1);
      end
      if (cmd.out_load) begin
         out_status_ff <= status_ff;
         out_occ_ff    <= occ_ff;
         out_found_ff  <= found_ff;
         out_dist_ff   <= dist_sat;
      end
   end

   // map bookkeeping: staging goes to the inactive bank, a good check swaps banks
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         xor_ff    <= '0;
         active_ff <= 1'b0;
         loaded_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            count_ff <= count_ff + BCW'(1);
            xor_ff   <= xor_ff ^ db_ff;
         end
         if (cmd.check_op) begin
            if (count_ff == BCW'(MAP_BYTES) && xor_ff == db_ff) begin
               active_ff <= !active_ff;
               loaded_ff <= 1'b1;
            end
            count_ff <= '0;
            xor_ff   <= '0;
         end
      end
   end

   assign sts.op        = op_ff;
   assign sts.div_done  = div_done_ff;
   assign sts.scan_last = (cell_ff == CW'(CELL_COUNT - 1));
   assign sts.scan_hit  = hit;
   assign sts.sqrt_done = (sq_cnt_ff == RCW'(RH));

   assign rsp_tdata = {7'd0, out_dist_ff, out_found_ff, out_occ_ff, out_status_ff};

endmodule

@@ rtl/occupancy_grid_query_engine_top.sv @@
// top level of the occupancy grid query engine
// depends on ogq_pkg, ogq_ctrl, ogq_dp (which holds two ogq_ram banks)
//
// channel  dir  handshake             payload
// req      in   req_tvalid/req_tready  tuser: opcode; tdata: byte, x, y, radius
// rsp      out  rsp_tvalid/rsp_tready  tdata: status, occupied, found, distance
//
// load, check and unused opcodes: decode, then straight to the finish state
// point query: one reciprocal multiply for the cell then a registered ram read
// zone and nearest: a read state and an accumulate state per cell scanned (one shared
// multiplier pair and one ram read port); nearest adds one square root bit per cycle
// reset: synchronous; the map reads empty until the first good check byte
// a finished result waits in the output register; the next request is taken
// while it waits, and only a second finished result stalls on rsp_tready
module occupancy_grid_query_engine_top #(
   parameter int GRID_COLS = 32,
   parameter int GRID_ROWS = 16,
   parameter int CELL_MM   = 150
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [2:0]  req_tuser,   // opcode
   input  logic [47:0] req_tdata,   // data_byte, pos_x, pos_y, radius, zero pad
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata    // status, occupied, found, distance, zero pad
);

   // command and status between sequencer and datapath
   ogq_pkg::cmd_type cmd;
   ogq_pkg::sts_type sts;

   ogq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   ogq_dp #(
      .GRID_COLS (GRID_COLS),
      .GRID_ROWS (GRID_ROWS),
      .CELL_MM   (CELL_MM)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .req_tuser (req_tuser),
      .req_tdata (req_tdata),
      .rsp_tdata (rsp_tdata)
   );

endmodule
